// ===== rtl/core/cppm_rssi_capture_decoder_defines.svh =====
//------------------------------------------------------------------------------
// cppm_rssi_capture_decoder_defines.svh
// Assertion macros for the CPPM / RSSI capture decoder.
//------------------------------------------------------------------------------
`ifndef CPPM_RSSI_CAPTURE_DECODER_DEFINES_SVH
`define CPPM_RSSI_CAPTURE_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked on every rising edge outside reset
`define CRD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cppm_rssi check failed");
// next-cycle implication
`define CRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cppm_rssi check failed");
`else
`define CRD_ASSERT_SAME(lbl, ante, cons)
`define CRD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/cppm_rssi_pkg.sv =====
//------------------------------------------------------------------------------
// cppm_rssi_pkg
// Shared types and constants of the CPPM / RSSI capture decoder.
//------------------------------------------------------------------------------
`default_nettype none

package cppm_rssi_pkg;

  localparam int TS_W     = 16;
  localparam int PCT_W    = 7;
  localparam int RATE_W   = 27;
  localparam int DIV_W    = 27;
  localparam int POS_W    = 5;
  localparam int IDX_W    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 27;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int TIMER_BITS_DEF   = 16;

  localparam logic [PCT_W-1:0]  RSSI_FULL = 7'd100;
  localparam logic [TS_W-1:0]   WEAK_MAX  = 16'hffff;

  localparam logic [TS_W-1:0]   SYNC_MIN_RST   = 16'd2700;
  localparam logic [TS_W-1:0]   SYNC_MAX_RST   = 16'd20000;
  localparam logic [PCT_W-1:0]  THRESH_RST     = 7'd20;
  localparam logic [TS_W-1:0]   TIMEOUT_RST    = 16'd100;
  localparam logic [RATE_W-1:0] TIMER_RATE_RST = 27'd1000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_MODE  = 3'd0,
    REG_SYNC_MIN    = 3'd1,
    REG_SYNC_MAX    = 3'd2,
    REG_RSSI_THRESH = 3'd3,
    REG_RSSI_TMO    = 3'd4,
    REG_TIMER_RATE  = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDBK,
    ST_DIV,
    ST_DONE
  } dec_state_t;

  typedef struct packed {
    logic            req_type;
    logic [TS_W-1:0] capture_value;
    logic [TS_W-1:0] rssi_high_time;
  } in_item_t;

  typedef struct packed {
    logic              link_active;
    logic              frame_sync;
    logic              channel_written;
    logic [IDX_W-1:0]  written_index;
    logic [TS_W-1:0]   pulse_width;
    logic [POS_W-1:0]  channels_in_frame;
    logic [PCT_W-1:0]  rssi_percent;
    logic [RATE_W-1:0] rssi_frequency_hz;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/cppm_rssi_ram.sv =====
//------------------------------------------------------------------------------
// cppm_rssi_ram
// Single-port synchronous RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module cppm_rssi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/cppm_rssi_div.sv =====
//------------------------------------------------------------------------------
// cppm_rssi_div
// Two-lane restoring divider: two dividends over one 16-bit divisor, one
// quotient bit per lane each cycle.
//------------------------------------------------------------------------------
`default_nettype none

module cppm_rssi_div
  import cppm_rssi_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [TS_W-1:0]  divisor,
  input  wire logic [DIV_W-1:0] dividend_a,
  input  wire logic [DIV_W-1:0] dividend_b,
  output logic                  done,
  output logic      [DIV_W-1:0] quot_a,
  output logic      [DIV_W-1:0] quot_b
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TS_W-1:0]  div_r, div_nxt;
  logic [TS_W-1:0]  rem_a_r, rem_a_nxt, rem_b_r, rem_b_nxt;
  logic [DIV_W-1:0] dvd_a_r, dvd_a_nxt, dvd_b_r, dvd_b_nxt;

  logic [TS_W:0] sh_a, sh_b, dext;
  logic          ge_a, ge_b;

  always_comb begin
    dext = {1'b0, div_r};
    sh_a = {rem_a_r, dvd_a_r[DIV_W-1]};
    sh_b = {rem_b_r, dvd_b_r[DIV_W-1]};
    ge_a = (sh_a >= dext);
    ge_b = (sh_b >= dext);

    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    div_nxt   = div_r;
    rem_a_nxt = rem_a_r;
    rem_b_nxt = rem_b_r;
    dvd_a_nxt = dvd_a_r;
    dvd_b_nxt = dvd_b_r;

    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = CNT_W'(DIV_W - 1);
      div_nxt   = divisor;
      rem_a_nxt = '0;
      rem_b_nxt = '0;
      dvd_a_nxt = dividend_a;
      dvd_b_nxt = dividend_b;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract where it fits
      rem_a_nxt = ge_a ? TS_W'(sh_a - dext) : sh_a[TS_W-1:0];
      rem_b_nxt = ge_b ? TS_W'(sh_b - dext) : sh_b[TS_W-1:0];
      dvd_a_nxt = {dvd_a_r[DIV_W-2:0], ge_a};
      dvd_b_nxt = {dvd_b_r[DIV_W-2:0], ge_b};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    div_r   <= div_nxt;
    rem_a_r <= rem_a_nxt;
    rem_b_r <= rem_b_nxt;
    dvd_a_r <= dvd_a_nxt;
    dvd_b_r <= dvd_b_nxt;
  end

  assign done   = done_r;
  assign quot_a = dvd_a_r;
  assign quot_b = dvd_b_r;

endmodule

`default_nettype wire

// ===== rtl/core/cppm_rssi_capture_decoder.sv =====
//------------------------------------------------------------------------------
// cppm_rssi_capture_decoder
// Path: a CPPM edge, a zero period or PWM mode passes the execute and done
//   states; a stored channel width adds a read back from the channel RAM; an
//   RSSI event waits in the divide state for the 27-step two-lane divider.
// Flow: one word at a time; the next input word is taken once the result
//   sits in the output register.
// Reset: synchronous; clears link, counters and RSSI values, restores register
//   defaults. The channel RAM is not cleared: each entry is written before read.
//------------------------------------------------------------------------------
`default_nettype none
`include "cppm_rssi_capture_decoder_defines.svh"

module cppm_rssi_capture_decoder
  import cppm_rssi_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int TIMER_BITS   = TIMER_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CW = (TIMER_BITS > TS_W) ? TIMER_BITS : TS_W;

  // configuration
  logic              cfg_mode_r;
  logic [TS_W-1:0]   cfg_sync_min_r, cfg_sync_max_r, cfg_tmo_r;
  logic [PCT_W-1:0]  cfg_thresh_r;
  logic [RATE_W-1:0] cfg_rate_r;

  // decoder state
  dec_state_t        state_r, state_nxt;
  in_item_t          item_r, item_nxt;
  logic [TIMER_BITS-1:0] last_ts_r, last_ts_nxt;
  logic [POS_W-1:0]  chan_pos_r, chan_pos_nxt;
  logic              link_up_r, link_up_nxt;
  logic [POS_W-1:0]  frame_cnt_r, frame_cnt_nxt;
  logic [TS_W-1:0]   weak_cnt_r, weak_cnt_nxt;
  logic [PCT_W-1:0]  duty_r, duty_nxt;
  logic [RATE_W-1:0] freq_r, freq_nxt;
  logic              sync_r, sync_nxt;
  logic              written_r, written_nxt;
  logic [IDX_W-1:0]  widx_r, widx_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              in_accept, out_load;
  logic [TIMER_BITS-1:0] ts, interval;
  logic [CW-1:0]     ival_c;
  logic              is_gap, in_win;
  logic [TS_W-1:0]   width16;
  logic [22:0]       duty_num;
  logic [PCT_W-1:0]  duty_sat;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_addr;
  logic [TS_W-1:0]   ram_rdata;

  logic              div_start, div_done;
  logic [DIV_W-1:0]  quot_a, quot_b;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r     <= 1'b0;
      cfg_sync_min_r <= SYNC_MIN_RST;
      cfg_sync_max_r <= SYNC_MAX_RST;
      cfg_thresh_r   <= THRESH_RST;
      cfg_tmo_r      <= TIMEOUT_RST;
      cfg_rate_r     <= TIMER_RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_INPUT_MODE:  cfg_mode_r     <= cfg_wdata[0];
        REG_SYNC_MIN:    cfg_sync_min_r <= cfg_wdata[TS_W-1:0];
        REG_SYNC_MAX:    cfg_sync_max_r <= cfg_wdata[TS_W-1:0];
        REG_RSSI_THRESH: cfg_thresh_r   <= cfg_wdata[PCT_W-1:0];
        REG_RSSI_TMO:    cfg_tmo_r      <= cfg_wdata[TS_W-1:0];
        REG_TIMER_RATE:  cfg_rate_r     <= cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // interval with timer wrap, compared at the wider of timer and field width
  always_comb begin
    ts       = TIMER_BITS'(item_r.capture_value);
    interval = ts - last_ts_r;
    ival_c   = CW'(interval);
    is_gap   = ival_c > CW'(cfg_sync_min_r);
    in_win   = ival_c < CW'(cfg_sync_max_r);
    width16  = TS_W'(interval);
    duty_num = 23'(item_r.rssi_high_time) * 23'(RSSI_FULL);
    duty_sat = (quot_a > DIV_W'(RSSI_FULL)) ? RSSI_FULL : quot_a[PCT_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    last_ts_nxt   = last_ts_r;
    chan_pos_nxt  = chan_pos_r;
    link_up_nxt   = link_up_r;
    frame_cnt_nxt = frame_cnt_r;
    weak_cnt_nxt  = weak_cnt_r;
    duty_nxt      = duty_r;
    freq_nxt      = freq_r;
    sync_nxt      = sync_r;
    written_nxt   = written_r;
    widx_nxt      = widx_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_addr      = chan_pos_r[AW-1:0];
    div_start     = 1'b0;
    out_load      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          item_nxt  = in_data;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        sync_nxt    = 1'b0;
        written_nxt = 1'b0;
        widx_nxt    = '0;
        state_nxt   = ST_DONE;
        if (!cfg_mode_r && !item_r.req_type) begin
          last_ts_nxt = ts;
          if (link_up_r) begin
            if (is_gap) begin
              frame_cnt_nxt = chan_pos_r;
              chan_pos_nxt  = '0;
              sync_nxt      = 1'b1;
            end else if (chan_pos_r >= POS_W'(NUM_CHANNELS)) begin
              // no sync after a full frame: drop the link
              link_up_nxt = 1'b0;
            end else begin
              ram_we       = 1'b1;
              written_nxt  = 1'b1;
              widx_nxt     = IDX_W'(chan_pos_r);
              chan_pos_nxt = chan_pos_r + 1'b1;
              state_nxt    = ST_RDBK;
            end
          end else if (is_gap && in_win && (weak_cnt_r <= cfg_tmo_r)) begin
            chan_pos_nxt = '0;
            link_up_nxt  = 1'b1;
          end
        end else if (!cfg_mode_r) begin
          if (item_r.capture_value == '0) begin
            duty_nxt = '0;
            freq_nxt = '0;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end

      ST_RDBK: begin
        ram_re    = 1'b1;
        ram_addr  = widx_r[AW-1:0];
        state_nxt = ST_DONE;
      end

      ST_DIV: begin
        if (div_done) begin
          duty_nxt = duty_sat;
          freq_nxt = quot_b;
          if (duty_sat < cfg_thresh_r) begin
            if (weak_cnt_r > cfg_tmo_r) begin
              link_up_nxt = 1'b0;
            end else if (weak_cnt_r != WEAK_MAX) begin
              weak_cnt_nxt = weak_cnt_r + 1'b1;
            end
          end else begin
            weak_cnt_nxt = '0;
          end
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        // hold the result until the output register frees up
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = (out_valid_r && out_stall) || out_load;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_data_nxt.link_active       = link_up_r;
      out_data_nxt.frame_sync        = sync_r;
      out_data_nxt.channel_written   = written_r;
      out_data_nxt.written_index     = widx_r;
      out_data_nxt.pulse_width       = written_r ? ram_rdata : '0;
      out_data_nxt.channels_in_frame = frame_cnt_r;
      out_data_nxt.rssi_percent      = duty_r;
      out_data_nxt.rssi_frequency_hz = freq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_ts_r   <= '0;
      chan_pos_r  <= '0;
      link_up_r   <= 1'b0;
      frame_cnt_r <= '0;
      weak_cnt_r  <= '0;
      duty_r      <= '0;
      freq_r      <= '0;
      sync_r      <= 1'b0;
      written_r   <= 1'b0;
      widx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_ts_r   <= last_ts_nxt;
      chan_pos_r  <= chan_pos_nxt;
      link_up_r   <= link_up_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      weak_cnt_r  <= weak_cnt_nxt;
      duty_r      <= duty_nxt;
      freq_r      <= freq_nxt;
      sync_r      <= sync_nxt;
      written_r   <= written_nxt;
      widx_r      <= widx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  cppm_rssi_ram #(
    .WIDTH (TS_W),
    .DEPTH (NUM_CHANNELS)
  ) u_chan_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (width16),
    .rdata (ram_rdata)
  );

  cppm_rssi_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .divisor    (item_r.capture_value),
    .dividend_a (DIV_W'(duty_num)),
    .dividend_b (DIV_W'(cfg_rate_r)),
    .done       (div_done),
    .quot_a     (quot_a),
    .quot_b     (quot_b)
  );

  `CRD_ASSERT_SAME(a_pos_bound, 1'b1, chan_pos_r <= POS_W'(NUM_CHANNELS))
  `CRD_ASSERT_SAME(a_duty_bound, 1'b1, duty_r <= RSSI_FULL)
  `CRD_ASSERT_SAME(a_div_owner, div_done, state_r == ST_DIV)
  `CRD_ASSERT_SAME(a_write_link, out_valid_r && out_data_r.channel_written, out_data_r.link_active)
  `CRD_ASSERT_NEXT(a_accept_exec, in_valid && !in_stall, state_r == ST_EXEC)

endmodule

`default_nettype wire
